// File: hdl/bmf_pkg.sv
`timescale 1ns / 1ps
package bmf_pkg;

  localparam int MAX_FRAMES = 9;
  localparam int SAMPLE_W   = 8;
  localparam int CNT_W      = 4;
  localparam int RANK_W     = $clog2(MAX_FRAMES);
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index as carried in the word-address bit of paddr.
  localparam logic REG_COUNT_IN_USE = 1'b0;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_FRAMES);

  typedef logic [MAX_FRAMES-1:0][SAMPLE_W-1:0] sample_vec_t;

  typedef struct packed {
    logic                hit;
    logic [SAMPLE_W-1:0] value;
  } lane_res_t;

  typedef lane_res_t [MAX_FRAMES-1:0] lane_res_vec_t;

  // A count of zero behaves as one, a count above the frame limit as the limit.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    n = cnt;
    if (n == '0) begin
      n = CNT_W'(1);
    end
    if (n > CNT_W'(MAX_FRAMES)) begin
      n = CNT_W'(MAX_FRAMES);
    end
    return n;
  endfunction

endpackage

// File: hdl/bmf_regs.sv
`timescale 1ns / 1ps
module bmf_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bmf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bmf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bmf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [bmf_pkg::CNT_W-1:0]       count_in_use
);
  import bmf_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_in_use <= COUNT_RESET;
    end else if (wr_en && paddr[2] == REG_COUNT_IN_USE) begin
      count_in_use <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_COUNT_IN_USE) begin
      prdata = {{(APB_DATA_W-CNT_W){1'b0}}, count_in_use};
    end
  end

endmodule

// File: hdl/bmf_lane.sv
`timescale 1ns / 1ps
module bmf_lane (
  input  logic                          clk,
  input  logic [bmf_pkg::RANK_W-1:0]    lane_idx,
  input  bmf_pkg::sample_vec_t          samples,
  input  logic [bmf_pkg::MAX_FRAMES-1:0] used,
  input  logic [bmf_pkg::RANK_W-1:0]    target,
  output bmf_pkg::lane_res_t            res
);
  import bmf_pkg::*;

  logic [SAMPLE_W-1:0] own;
  logic [RANK_W-1:0]   rank_next;

  assign own = samples[lane_idx];

  // Ties are broken by frame index, so every used sample gets a distinct rank.
  always_comb begin
    rank_next = '0;
    for (int j = 0; j < MAX_FRAMES; j++) begin
      if (used[j] && ((samples[j] < own) ||
                      (samples[j] == own && RANK_W'(j) < lane_idx))) begin
        rank_next = rank_next + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    res.hit   <= used[lane_idx] && (rank_next == target);
    res.value <= own;
  end

endmodule

// File: hdl/bmf_merge.sv
`timescale 1ns / 1ps
module bmf_merge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  input  bmf_pkg::lane_res_vec_t       res,
  output logic                         strobe,
  output logic [bmf_pkg::SAMPLE_W-1:0] median_byte
);
  import bmf_pkg::*;

  logic [SAMPLE_W-1:0] pick;

  // Exactly one lane hits, so an OR of the gated values selects it.
  always_comb begin
    pick = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      pick = pick | (res[i].value & {SAMPLE_W{res[i].hit}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= valid;
    end
    median_byte <= pick;
  end

endmodule

// File: hdl/bytewise_median_of_frames.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Direction  Handshake
// input     start, busy, sample_0 .. sample_8       in         start & !busy
// result    strobe, median_byte                     out        strobe, one cycle
// config    psel penable pwrite paddr pwdata prdata  in/out     APB, pready high
//
// A new item is taken every cycle; busy never rises.
// An accepted item passes through the input register, the nine rank lanes,
// then the merging register before its result appears.
// Reset is synchronous; it empties the pipeline and sets count_in_use to 9.
// The receiver cannot stall, so nothing holds the pipeline back.
module bytewise_median_of_frames (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bmf_pkg::SAMPLE_W-1:0]    sample_0,
  input  logic [bmf_pkg::SAMPLE_W-1:0]    sample_1,
  input  logic [bmf_pkg::SAMPLE_W-1:0]    sample_2,
  input  logic [bmf_pkg::SAMPLE_W-1:0]    sample_3,
  input  logic [bmf_pkg::SAMPLE_W-1:0]    sample_4,
  input  logic [bmf_pkg::SAMPLE_W-1:0]    sample_5,
  input  logic [bmf_pkg::SAMPLE_W-1:0]    sample_6,
  input  logic [bmf_pkg::SAMPLE_W-1:0]    sample_7,
  input  logic [bmf_pkg::SAMPLE_W-1:0]    sample_8,
  output logic                            strobe,
  output logic [bmf_pkg::SAMPLE_W-1:0]    median_byte,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bmf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bmf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bmf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import bmf_pkg::*;

  logic [CNT_W-1:0]      count_in_use;
  logic [CNT_W-1:0]      n_eff;
  logic                  accept;
  logic                  s1_valid;
  logic                  s2_valid;
  sample_vec_t           s1_samples;
  logic [MAX_FRAMES-1:0] s1_used;
  logic [RANK_W-1:0]     s1_target;
  lane_res_vec_t         lane_res;
  logic [MAX_FRAMES-1:0] lane_hits;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign n_eff  = eff_count(count_in_use);

  bmf_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .count_in_use (count_in_use)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
    if (accept) begin
      s1_samples <= {sample_8, sample_7, sample_6, sample_5, sample_4,
                     sample_3, sample_2, sample_1, sample_0};
      for (int i = 0; i < MAX_FRAMES; i++) begin
        s1_used[i] <= CNT_W'(i) < n_eff;
      end
      s1_target <= RANK_W'(n_eff >> 1);
    end
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_lane
    bmf_lane u_lane (
      .clk      (clk),
      .lane_idx (RANK_W'(g)),
      .samples  (s1_samples),
      .used     (s1_used),
      .target   (s1_target),
      .res      (lane_res[g])
    );
    assign lane_hits[g] = lane_res[g].hit;
  end

  bmf_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .valid       (s2_valid),
    .res         (lane_res),
    .strobe      (strobe),
    .median_byte (median_byte)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 strobe)
    else $error("accepted beat did not produce a result three cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept, 3))
    else $error("result strobe without an accepted beat");

  a_one_lane: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $onehot(lane_hits))
    else $error("lanes did not agree on exactly one median");

  a_lane0_used: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_used[0])
    else $error("first sample not in use");
`endif

endmodule
